// File: hw/rtl/triangle_cosine_histogram_macros.svh
// Assertion macros shared by the triangle cosine histogram RTL
`ifndef TRIANGLE_COSINE_HISTOGRAM_MACROS_SVH
`define TRIANGLE_COSINE_HISTOGRAM_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while rst_n is low
`define TCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define TCH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TCH_ASSERT_IMP(lbl, ante, cons)
`define TCH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/tch_pkg.sv
// Shared types, codes and constants of the triangle cosine histogram
package tch_pkg;

  localparam int MAX_BINS_DEF  = 64;
  localparam int SIDE_BITS_DEF = 16;

  localparam int FLD_W  = 16;  // width of side and weight fields
  localparam int BINF_W = 6;   // width of bin number fields
  localparam int NB_W   = 7;   // num_bins register and bin index width
  localparam int SUM_W  = 48;
  localparam int STAT_W = 2;

  localparam logic [NB_W-1:0] NUM_BINS_RST = NB_W'(16);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_SIDE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_BIN   = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [FLD_W-1:0]  side_12;
    logic [FLD_W-1:0]  side_13;
    logic [FLD_W-1:0]  side_23;
    logic [FLD_W-1:0]  weight;
    logic [BINF_W-1:0] read_bin;
  } in_item_t;

  typedef struct packed {
    logic [BINF_W-1:0] bin_number;
    logic [SUM_W-1:0]  bin_total;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // bin finder to controller
  typedef struct packed {
    logic            done;
    logic [NB_W-1:0] bin;
  } cb_res_t;

endpackage

// File: hw/rtl/tch_ram.sv
// Generic simple dual-port RAM with registered read
module tch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tch_cosbin.sv
// Cosine bin finder: law-of-cosines products and a radix-2 quotient search
`include "triangle_cosine_histogram_macros.svh"
module tch_cosbin #(
  parameter int SIDE_BITS = tch_pkg::SIDE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [SIDE_BITS-1:0]      side_a,
  input  logic [SIDE_BITS-1:0]      side_b,
  input  logic [SIDE_BITS-1:0]      side_c,
  input  logic [tch_pkg::NB_W-1:0]  nbins,
  output tch_pkg::cb_res_t          res
);

  localparam int NB_W  = tch_pkg::NB_W;
  localparam int S_W   = SIDE_BITS + 1;
  localparam int Q_W   = SIDE_BITS + 2;
  localparam int PQ_W  = 2 * SIDE_BITS + 3;
  localparam int AB_W  = 2 * SIDE_BITS;
  localparam int L_W   = PQ_W + NB_W;
  localparam int QT_W  = NB_W + 1;
  localparam int CNT_W = $clog2(QT_W);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MUL1 = 3'd1;
  localparam logic [2:0] C_MUL2 = 3'd2;
  localparam logic [2:0] C_DIV  = 3'd3;
  localparam logic [2:0] C_FIN  = 3'd4;

  logic [2:0]           st_r, st_nxt;
  logic                 done_r, done_nxt;
  logic [S_W-1:0]       p_r, p_nxt;
  logic [Q_W-1:0]       q_r, q_nxt;
  logic [SIDE_BITS-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [NB_W-1:0]      n_r, n_nxt;
  logic [PQ_W-1:0]      pq_r, pq_nxt;
  logic [AB_W-1:0]      ab_r, ab_nxt;
  logic [L_W-1:0]       rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [QT_W-1:0]      qt_r, qt_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NB_W-1:0]      k_r, k_nxt;
  logic [S_W-1:0]       sum_ab;
  logic [NB_W-1:0]      n_m1;
  logic                 ge;

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    p_nxt    = p_r;
    q_nxt    = q_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    n_nxt    = n_r;
    pq_nxt   = pq_r;
    ab_nxt   = ab_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    qt_nxt   = qt_r;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    sum_ab   = S_W'(side_a) + S_W'(side_b);
    n_m1     = n_r - NB_W'(1);
    ge       = (rem_r >= dsh_r);
    unique case (st_r)
      C_IDLE: begin
        if (start) begin
          // (a+b-c) clipped at zero, and (a+b+c)
          p_nxt  = (sum_ab > S_W'(side_c)) ? (sum_ab - S_W'(side_c)) : '0;
          q_nxt  = Q_W'(sum_ab) + Q_W'(side_c);
          a_nxt  = side_a;
          b_nxt  = side_b;
          n_nxt  = nbins;
          st_nxt = C_MUL1;
        end
      end
      C_MUL1: begin
        pq_nxt = PQ_W'(p_r) * PQ_W'(q_r);
        ab_nxt = AB_W'(a_r) * AB_W'(b_r);
        st_nxt = C_MUL2;
      end
      C_MUL2: begin
        // numerator p*q*n over divisor 4ab, divisor aligned to the top quotient bit
        rem_nxt = L_W'(pq_r) * L_W'(n_r);
        dsh_nxt = L_W'({ab_r, 2'b00}) << (QT_W - 1);
        qt_nxt  = '0;
        cnt_nxt = CNT_W'(QT_W - 1);
        st_nxt  = C_DIV;
      end
      C_DIV: begin
        rem_nxt = ge ? (rem_r - dsh_r) : rem_r;
        qt_nxt  = {qt_r[QT_W-2:0], ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          st_nxt = C_FIN;
        end
      end
      C_FIN: begin
        // top quotient bit set means far past the last bin
        if (qt_r[QT_W-1] || (qt_r[QT_W-2:0] > n_m1)) begin
          k_nxt = n_m1;
        end else begin
          k_nxt = qt_r[QT_W-2:0];
        end
        done_nxt = 1'b1;
        st_nxt   = C_IDLE;
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
    pq_r  <= pq_nxt;
    ab_r  <= ab_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    qt_r  <= qt_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
  end

  assign res.done = done_r;
  assign res.bin  = k_r;

  `TCH_ASSERT_IMP(a_start_when_idle, start, st_r == C_IDLE)
  `TCH_ASSERT_IMP(a_bin_in_range, done_r, k_r < n_r)
  `TCH_ASSERT_IMP(a_fin_after_div, st_r == C_FIN, $past(st_r) == C_DIV)

endmodule

// File: hw/rtl/triangle_cosine_histogram.sv
// Top level: request control and read-modify-write of the bin store
// After reset the bin store is cleared one entry per cycle, so busy stays high
// until all MAX_BINS entries (64 by default) are clear; num_bins writes are
// taken during that time. A read of a bin is accepted, then the memory is
// read, then the result is given. A rejected request (zero side, or read at or
// beyond the clamped num_bins) answers in the next cycle and leaves busy low.
// An add runs through two multiply stages, eight quotient steps of the bin
// finder and one clamp step, then reads the bin, writes it back and gives the
// result. out_strobe marks each result for one cycle; there is no way to hold
// it, so capture it then.
`include "triangle_cosine_histogram_macros.svh"
module triangle_cosine_histogram #(
  parameter int MAX_BINS  = tch_pkg::MAX_BINS_DEF,
  parameter int SIDE_BITS = tch_pkg::SIDE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  tch_pkg::in_item_t        in_data,
  output logic                     out_strobe,
  output tch_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic [tch_pkg::NB_W-1:0] cfg_wdata
);

  localparam int NB_W  = tch_pkg::NB_W;
  localparam int SUM_W = tch_pkg::SUM_W;
  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int NB_TOP = (2 ** NB_W) - 1;
  localparam logic [NB_W-1:0] NB_CAP =
    (MAX_BINS > NB_TOP) ? NB_W'(NB_TOP) : NB_W'(MAX_BINS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;
  localparam logic [1:0] S_RDW   = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [BIN_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [NB_W-1:0]          nbins_r;
  logic                     out_strobe_r, out_strobe_nxt;
  tch_pkg::out_item_t       out_r, out_nxt;
  logic                     rd_mode_r, rd_mode_nxt;
  logic [NB_W-1:0]          bin_r, bin_nxt;
  logic [tch_pkg::FLD_W-1:0] weight_r, weight_nxt;

  logic [NB_W-1:0]      eff_n;
  logic [SIDE_BITS-1:0] sa, sb, sc;
  logic                 zero_side;
  logic                 cb_start;
  tch_pkg::cb_res_t     cb_res;
  logic                 mem_we, mem_re;
  logic [BIN_W-1:0]     mem_waddr, mem_raddr;
  logic [SUM_W-1:0]     mem_wdata, mem_rdata;
  logic [SUM_W:0]       sum_full;
  logic [SUM_W-1:0]     sum_sat;

  assign sa = SIDE_BITS'(in_data.side_12);
  assign sb = SIDE_BITS'(in_data.side_13);
  assign sc = SIDE_BITS'(in_data.side_23);
  assign zero_side = (sa == '0) || (sb == '0) || (sc == '0);

  // zero acts as one bin, anything above the store depth as the full depth
  assign eff_n = (nbins_r == '0) ? NB_W'(1) : ((nbins_r > NB_CAP) ? NB_CAP : nbins_r);

  assign sum_full = {1'b0, mem_rdata} + (SUM_W + 1)'(weight_r);
  assign sum_sat  = sum_full[SUM_W] ? {SUM_W{1'b1}} : sum_full[SUM_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    rd_mode_nxt    = rd_mode_r;
    bin_nxt        = bin_r;
    weight_nxt     = weight_r;
    cb_start       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = BIN_W'(bin_r);
    mem_wdata      = sum_sat;
    mem_re         = 1'b0;
    mem_raddr      = BIN_W'(in_data.read_bin);
    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + BIN_W'(1);
        if (clr_cnt_r == BIN_W'(MAX_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_data.req_type == tch_pkg::REQ_READ) begin
            if ({1'b0, in_data.read_bin} >= eff_n) begin
              out_strobe_nxt     = 1'b1;
              out_nxt.bin_number = in_data.read_bin;
              out_nxt.bin_total  = '0;
              out_nxt.status     = tch_pkg::ST_BAD_BIN;
            end else begin
              mem_re      = 1'b1;
              rd_mode_nxt = 1'b1;
              bin_nxt     = NB_W'(in_data.read_bin);
              state_nxt   = S_RDW;
            end
          end else if (zero_side) begin
            out_strobe_nxt     = 1'b1;
            out_nxt.bin_number = '0;
            out_nxt.bin_total  = '0;
            out_nxt.status     = tch_pkg::ST_ZERO_SIDE;
          end else begin
            cb_start    = 1'b1;
            rd_mode_nxt = 1'b0;
            weight_nxt  = in_data.weight;
            state_nxt   = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (cb_res.done) begin
          mem_re    = 1'b1;
          mem_raddr = BIN_W'(cb_res.bin);
          bin_nxt   = cb_res.bin;
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        // read data is here; an add writes the saturated sum back
        out_strobe_nxt     = 1'b1;
        out_nxt.bin_number = bin_r[tch_pkg::BINF_W-1:0];
        out_nxt.status     = tch_pkg::ST_OK;
        if (rd_mode_r) begin
          out_nxt.bin_total = mem_rdata;
        end else begin
          mem_we            = 1'b1;
          out_nxt.bin_total = sum_sat;
        end
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      nbins_r      <= tch_pkg::NUM_BINS_RST;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        nbins_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    rd_mode_r <= rd_mode_nxt;
    bin_r     <= bin_nxt;
    weight_r  <= weight_nxt;
  end

  tch_cosbin #(
    .SIDE_BITS (SIDE_BITS)
  ) u_cosbin (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cb_start),
    .side_a (sa),
    .side_b (sb),
    .side_c (sc),
    .nbins  (eff_n),
    .res    (cb_res)
  );

  tch_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  `TCH_ASSERT_IMP(a_we_source, mem_we, (state_r == S_CLEAR) || ((state_r == S_RDW) && !rd_mode_r))
  `TCH_ASSERT_NXT(a_rdw_gives_result, state_r == S_RDW, out_strobe_r)
  `TCH_ASSERT_IMP(a_sum_no_wrap, (state_r == S_RDW) && !rd_mode_r, mem_wdata >= mem_rdata)
  `TCH_ASSERT_IMP(a_reject_zero_total, out_strobe_r && (out_r.status != tch_pkg::ST_OK), out_r.bin_total == '0)

endmodule
